[sv/qalu_pkg.sv]
`default_nettype none
package qalu_pkg;

	localparam int unsigned DIV_STEPS  = 49;
	localparam int unsigned SQRT_STEPS = 24;
	localparam logic [31:0] SQRT_FIRST_BIT = 32'h4000_0000;
	localparam logic [63:0] MUL_ROUND = 64'h0000_0000_0000_8000;

	typedef enum logic [2:0] {
		KIND_ADD  = 3'd0,
		KIND_SUB  = 3'd1,
		KIND_MUL  = 3'd2,
		KIND_DIV  = 3'd3,
		KIND_SQRT = 3'd4
	} kind_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  kind;
		logic        err;
		logic [31:0] res;
		logic [63:0] prod;
		logic [31:0] divisor;
		logic [31:0] drem;
		logic [48:0] dnum;
		logic [63:0] srem;
		logic [31:0] sq;
	} stage_t;

endpackage
`default_nettype wire

[sv/unsigned_q16_16_alu.sv]
`default_nettype none
// Unsigned Q16.16 arithmetic unit: add, subtract, multiply, divide and square
// root on two 32-bit operands, one result item with an error flag per input
// item. It is a pipeline that accepts one item every cycle unless the output
// stalls; each item passes from acceptance to the output register through one
// operand stage, loaded at acceptance, that also holds the multiplier, a row
// of 49 cells each doing one restoring divide step and, in the first 24, one
// square-root step, and one output stage that rounds the product and picks the
// result. The whole row moves together, so a stall on the output holds every
// stage and in_ready follows out_ready whenever the output register is full.
module unsigned_q16_16_alu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      result,
	output logic             error
);
	import qalu_pkg::*;

	logic        en;
	stage_t      chain [0:DIV_STEPS];
	stage_t      last;
	logic [63:0] prnd;
	logic        fin_err;
	logic [31:0] fin_res;

	// The pipeline advances whenever the output register is empty or drained.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	qalu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.take      (in_valid),
		.kind      (kind),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.st_s1     (chain[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		qalu_cell #(.STEP(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.st_in  (chain[i]),
			.st_q   (chain[i + 1])
		);
	end

	assign last = chain[DIV_STEPS];
	assign prnd = last.prod + MUL_ROUND;

	// Pick the result for the operation; the product is rounded here and an error zeroes the result.
	always_comb begin
		fin_err = last.err;
		fin_res = last.res;
		case (last.kind)
			KIND_MUL: begin
				fin_err = prnd[63:48] != 16'h0;
				fin_res = prnd[47:16];
			end
			KIND_DIV: begin
				fin_res = last.dnum[31:0];
			end
			KIND_SQRT: begin
				fin_res = {8'h00, last.sq[31:8]};
			end
			default: begin
				fin_res = last.res;
			end
		endcase
		if (fin_err) begin
			fin_res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= fin_res;
			error  <= fin_err;
		end
	end

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> result == 32'h0)
		else $error("error item carries a nonzero result");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output drain");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(chain[DIV_STEPS].dnum))
		else $error("pipeline moved during a stall");
`endif
endmodule
`default_nettype wire

[sv/qalu_front.sv]
`default_nettype none
module qalu_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           take,
	input  wire logic [2:0]     kind,
	input  wire logic [31:0]    operand_a,
	input  wire logic [31:0]    operand_b,
	output qalu_pkg::stage_t    st_s1
);
	import qalu_pkg::*;

	logic [32:0] sum;
	stage_t      nxt;

	assign sum = {1'b0, operand_a} + {1'b0, operand_b};

	always_comb begin
		nxt         = '0;
		nxt.valid   = take;
		nxt.kind    = kind;
		nxt.divisor = operand_b;
		nxt.dnum    = {1'b0, operand_a, 16'h0000} + {17'h0, 1'b0, operand_b[31:1]};
		nxt.srem    = {32'h0, operand_a};
		nxt.prod    = {32'h0, operand_a} * {32'h0, operand_b};
		case (kind)
			KIND_ADD: begin
				nxt.err = sum[32];
				nxt.res = sum[31:0];
			end
			KIND_SUB: begin
				nxt.err = operand_a < operand_b;
				nxt.res = operand_a - operand_b;
			end
			KIND_MUL, KIND_SQRT: begin
				nxt.err = 1'b0;
			end
			KIND_DIV: begin
				nxt.err = operand_b == 32'h0;
			end
			default: begin
				nxt.err = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else if (en) begin
			st_s1 <= nxt;
		end
	end
endmodule
`default_nettype wire

[sv/qalu_cell.sv]
`default_nettype none
module qalu_cell #(
	parameter int unsigned STEP = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire qalu_pkg::stage_t st_in,
	output qalu_pkg::stage_t    st_q
);
	import qalu_pkg::*;

	localparam logic [31:0] SBIT = SQRT_FIRST_BIT >> STEP;

	logic [32:0] dtry;
	logic        dge;
	logic [31:0] trial;
	logic        sge;
	stage_t      nxt;

	// One restoring divide step, plus one square-root step in the first cells.
	assign dtry  = {st_in.drem, st_in.dnum[48]};
	assign dge   = dtry >= {1'b0, st_in.divisor};
	assign trial = st_in.sq + SBIT;
	assign sge   = st_in.srem >= {32'h0, trial};

	always_comb begin
		nxt      = st_in;
		nxt.dnum = {st_in.dnum[47:0], dge};
		nxt.drem = dge ? 32'(dtry - {1'b0, st_in.divisor}) : dtry[31:0];
		if (STEP < SQRT_STEPS) begin
			if (sge) begin
				nxt.srem = (st_in.srem - {32'h0, trial}) << 1;
				nxt.sq   = trial + SBIT;
			end else begin
				nxt.srem = st_in.srem << 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q <= nxt;
		end
	end
endmodule
`default_nettype wire

[sim/tb_top.sv]
`default_nettype none
// Testbench for the unsigned Q16.16 arithmetic unit.
module tb_top;
	import qalu_pkg::*;

	// One operation item as offered to the block.
	typedef struct {
		logic [2:0]  op;
		logic [31:0] a;
		logic [31:0] b;
	} op_item_t;

	// One expected result item.
	typedef struct {
		logic [31:0] value;
		logic        flag;
	} alu_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  kind;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] result;
	logic        error;

	op_item_t    pending_ops[$];
	alu_result_t expected_results[$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_off_cycles;
	int unsigned mismatch_count;
	int unsigned results_checked;
	int unsigned ops_sent;
	bit          stimulus_done;

	// Marks that the item on the input was accepted at the last rising edge.
	logic in_ready_seen;

	unsigned_q16_16_alu u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.error     (error)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Bit-by-bit square root; the result keeps the Q16.16 point.
	function automatic logic [31:0] qsqrt(input logic [31:0] radicand);
		logic [63:0] rem;
		logic [31:0] root;
		logic [31:0] probe;
		logic [31:0] trial;
		rem = {32'd0, radicand};
		root = '0;
		probe = SQRT_FIRST_BIT;
		while (probe > 32'h40) begin
			trial = root + probe;
			if (rem >= {32'd0, trial}) begin
				rem = rem - {32'd0, trial};
				root = trial + probe;
			end
			rem = rem << 1;
			probe = probe >> 1;
		end
		return root >> 8;
	endfunction

	// Computes the result item that one operation must give.
	function automatic alu_result_t alu_predict(input op_item_t it);
		alu_result_t r;
		logic [32:0] sum;
		logic [63:0] prod;
		logic [63:0] num;
		r.value = '0;
		r.flag = 1'b0;
		case (it.op)
			KIND_ADD: begin
				sum = {1'b0, it.a} + {1'b0, it.b};
				if (sum[32]) r.flag = 1'b1;
				else r.value = sum[31:0];
			end
			KIND_SUB: begin
				if (it.a < it.b) r.flag = 1'b1;
				else r.value = it.a - it.b;
			end
			KIND_MUL: begin
				prod = {32'd0, it.a} * {32'd0, it.b} + MUL_ROUND;
				if (prod[63:48] != 16'd0) r.flag = 1'b1;
				else r.value = prod[47:16];
			end
			KIND_DIV: begin
				if (it.b == 32'd0) begin
					r.flag = 1'b1;
				end else begin
					num = ({32'd0, it.a} << 16) + {33'd0, it.b[31:1]};
					num = num / {32'd0, it.b};
					r.value = num[31:0];
				end
			end
			KIND_SQRT: r.value = qsqrt(it.a);
			default: r.flag = 1'b1;
		endcase
		if (r.flag) r.value = '0;
		return r;
	endfunction

	// Random operand with a bias toward edge values and short magnitudes.
	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			1: return $urandom_range(0, 3);
			2: return $urandom_range(0, 32'h0001_FFFF);
			3: return $urandom_range(0, 32'h00FF_FFFF);
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_op(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b);
		op_item_t it;
		it.op = op;
		it.a = a;
		it.b = b;
		pending_ops.push_back(it);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	// Driver: inputs change on the falling edge only. The valid stays up until
	// the item is taken, so it is only ever assigned once per step.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready_seen) begin
			if (pending_ops.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
				op_item_t it;
				it = pending_ops.pop_front();
				in_valid <= 1'b1;
				kind <= it.op;
				operand_a <= it.a;
				operand_b <= it.b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ready_seen <= 1'b0;
		end else begin
			in_ready_seen <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				op_item_t it;
				it.op = kind;
				it.a = operand_a;
				it.b = operand_b;
				expected_results.push_back(alu_predict(it));
				ops_sent++;
			end
		end
	end

	// Receiver backpressure, with a long hold-off counted here when requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off_cycles != 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(1, 100) > recv_idle_pct);
		end
	end

	// Monitor: checks every accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", result, 32'd0);
			end else begin
				alu_result_t want;
				want = expected_results.pop_front();
				if (result !== want.value) report_mismatch("result", result, want.value);
				if (error !== want.flag)
					report_mismatch("error", {31'd0, error}, {31'd0, want.flag});
			end
			results_checked++;
		end
	end

	task automatic drain();
		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [31:0]  a;
		logic [31:0]  b;
		int unsigned  sel;
		in_valid = 1'b0;
		out_ready = 1'b0;
		kind = KIND_ADD;
		operand_a = '0;
		operand_b = '0;
		hold_off_cycles = 0;
		mismatch_count = 0;
		results_checked = 0;
		ops_sent = 0;
		send_idle_pct = 26;
		recv_idle_pct = 72;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items: carry and borrow edges, multiply overflow and rounding,
		// divide by zero and by one, square root extremes and undefined kinds.
		queue_op(KIND_ADD, 32'hFFFF_FFFF, 32'd0);
		queue_op(KIND_ADD, 32'hFFFF_FFFF, 32'd1);
		queue_op(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_op(KIND_SUB, 32'd0, 32'd0);
		queue_op(KIND_SUB, 32'd0, 32'd1);
		queue_op(KIND_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		queue_op(KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_op(KIND_MUL, 32'h0001_0000, 32'hFFFF_FFFF);
		queue_op(KIND_MUL, 32'h0000_8000, 32'h0000_0001);
		queue_op(KIND_MUL, 32'h0000_7FFF, 32'h0000_0001);
		queue_op(KIND_MUL, 32'h0001_0000, 32'h0001_0000);
		queue_op(KIND_MUL, 32'h0000_FFFF, 32'hFFFF_0000);
		queue_op(KIND_DIV, 32'h1234_5678, 32'd0);
		queue_op(KIND_DIV, 32'hFFFF_FFFF, 32'd1);
		queue_op(KIND_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_op(KIND_DIV, 32'd0, 32'hFFFF_FFFF);
		queue_op(KIND_DIV, 32'd1, 32'd3);
		queue_op(KIND_SQRT, 32'd0, 32'hFFFF_FFFF);
		queue_op(KIND_SQRT, 32'hFFFF_FFFF, 32'd0);
		queue_op(KIND_SQRT, 32'h0001_0000, 32'd0);
		queue_op(KIND_SQRT, 32'h0004_0000, 32'd5);
		queue_op(3'd5, 32'h1, 32'h1);
		queue_op(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_op(3'd7, 32'd0, 32'd0);

		for (int i = 0; i < 1150; i++) begin
			sel = $urandom_range(0, 99);
			a = rand_operand();
			b = rand_operand();
			if (sel < 3) queue_op(3'($urandom_range(5, 7)), a, b);
			else queue_op(3'(sel % 5), a, b);
			// Switch the idling pattern at the thirds of the random part.
			if (i == 383) begin
				drain();
				send_idle_pct = 72;
				recv_idle_pct = 26;
			end else if (i == 766) begin
				drain();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				// Long stall on the output while the sender keeps offering items.
				hold_off_cycles = 150;
			end
		end
		drain();
		repeat (60) @(posedge clk);

		$display("Covered %0d items over add, subtract, multiply, divide, square root", ops_sent);
		$display("and undefined kinds, with %0d results checked under backpressure.",
			results_checked);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

[unsigned_q16_16_alu.f]
sv/qalu_pkg.sv
sv/qalu_front.sv
sv/qalu_cell.sv
sv/unsigned_q16_16_alu.sv
sim/tb_top.sv
